### hw/rtl/c8wpd_pkg.sv
// Shared types, constants and the CRC-8 byte update for the word-pair deframer.
// No dependencies; imported by every module of the block.
package c8wpd_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned INDEX_W   = 4;
	localparam int unsigned PHASE_W   = 3;

	localparam logic [7:0] CRC_INIT  = 8'hFF;
	localparam logic [7:0] CRC_POLY  = 8'h31;

	// Byte offsets inside one six-byte value (two data/data/CRC triplets).
	localparam logic [PHASE_W-1:0] PH_D0   = 3'd0;
	localparam logic [PHASE_W-1:0] PH_D1   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_C0   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_D3   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_D4   = 3'd4;
	localparam logic [PHASE_W-1:0] PH_LAST = 3'd5;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data_byte;
		logic              frame_start;
	} in_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value_bits;
		logic [INDEX_W-1:0] value_index;
		logic               value_ok;
		logic               frame_end;
		logic               frame_ok;
	} result_t;

	// MSB-first CRC-8 update over one byte, polynomial 0x31.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### hw/rtl/crc8_word_pair_deframer.sv
// Top level of the CRC-8 word-pair deframer.
// Depends on c8wpd_pkg, c8wpd_in_stage, c8wpd_track and c8wpd_out_stage.
//
// Usage:
//   Byte channel (byte_valid/byte_ready, data_byte, frame_start) carries the
//   response stream one byte per transaction. frame_start marks byte 0 of a
//   frame and drops any partial value; without it the byte after the last
//   byte of a frame opens the next frame.
//   A frame is VALUE_COUNT values of six bytes each: data, data, CRC, data,
//   data, CRC. CRC-8 uses polynomial 0x31, seed 0xFF, no final xor.
//   Value channel (value_valid/value_ready) delivers one transaction per
//   sixth byte: value_bits (bytes 0,1,3,4 big-endian), value_index,
//   value_ok (both CRCs good), frame_end on the last value and frame_ok
//   (every CRC of the frame good, set only with frame_end).
//   A bad CRC never stops the stream; it only clears the flags.
// Timing:
//   One byte per cycle sustained while value_ready is high. The sixth byte
//   waits in the input register; the result register loads as it moves on
//   and drives value_valid. The CRC update and value assembly sit in between.
// Reset and stall:
//   arst_n empties both registers and returns the tracker to byte 0 of a
//   frame. If the receiver holds value_ready low, the held value stays put,
//   one more byte waits in the input register, then byte_ready drops.
module crc8_word_pair_deframer
	import c8wpd_pkg::*;
#(
	parameter int unsigned VALUE_COUNT = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  logic [BYTE_W-1:0]  data_byte,
	input  logic               frame_start,
	output logic               value_valid,
	input  logic               value_ready,
	output logic [VALUE_W-1:0] value_bits,
	output logic [INDEX_W-1:0] value_index,
	output logic               value_ok,
	output logic               frame_end,
	output logic               frame_ok
);

	in_item_t item;
	result_t  result;
	logic     emit;
	logic     take;
	logic     fire;

	// Advance the held byte whenever the result register has room.
	assign fire = item.valid && take;

	c8wpd_in_stage u_in (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.advance     (fire),
		.item        (item)
	);

	c8wpd_track #(
		.VALUE_COUNT (VALUE_COUNT)
	) u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item),
		.emit   (emit),
		.result (result)
	);

	c8wpd_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (emit),
		.result      (result),
		.take        (take),
		.value_valid (value_valid),
		.value_ready (value_ready),
		.value_bits  (value_bits),
		.value_index (value_index),
		.value_ok    (value_ok),
		.frame_end   (frame_end),
		.frame_ok    (frame_ok)
	);

endmodule

### hw/rtl/c8wpd_in_stage.sv
// Input register of the word-pair deframer.
// Depends on c8wpd_pkg.
module c8wpd_in_stage
	import c8wpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_ready,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              frame_start,
	input  logic              advance,
	output in_item_t          item
);

	logic              valid_s1;
	logic [BYTE_W-1:0] data_byte_s1;
	logic              frame_start_s1;

	// Refill in the same cycle the held byte moves on.
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			data_byte_s1   <= data_byte;
			frame_start_s1 <= frame_start;
		end
	end

	assign item = '{valid: valid_s1, data_byte: data_byte_s1, frame_start: frame_start_s1};

endmodule

### hw/rtl/c8wpd_track.sv
// Frame tracker: byte position, triplet CRC check and value assembly.
// Depends on c8wpd_pkg.
module c8wpd_track
	import c8wpd_pkg::*;
#(
	parameter int unsigned VALUE_COUNT = 10
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fire,
	input  in_item_t item,
	output logic     emit,
	output result_t  result
);

	localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(VALUE_COUNT - 1);

	logic [PHASE_W-1:0] phase_q;
	logic [INDEX_W-1:0] count_q;
	logic [7:0]         crc_q;
	logic [VALUE_W-1:0] hold_q;
	logic               vgood_q;
	logic               fgood_q;

	logic [PHASE_W-1:0] phase;
	logic [INDEX_W-1:0] count;
	logic [7:0]         crc;
	logic               vgood;
	logic               fgood;
	logic               is_data0;
	logic               is_crc;
	logic [7:0]         crc_upd;
	logic               mismatch;
	logic               vgood_n;
	logic               fgood_n;
	logic               last;

	// Frame start restarts position, count, CRC and flags.
	assign phase = item.frame_start ? PH_D0    : phase_q;
	assign count = item.frame_start ? '0       : count_q;
	assign crc   = item.frame_start ? CRC_INIT : crc_q;
	assign vgood = item.frame_start ? 1'b1     : vgood_q;
	assign fgood = item.frame_start ? 1'b1     : fgood_q;

	always_comb begin
		is_data0 = 1'b0;
		is_crc   = 1'b0;
		case (phase)
			PH_D0, PH_D3:    is_data0 = 1'b1;
			PH_C0, PH_LAST:  is_crc   = 1'b1;
			default:         is_data0 = 1'b0;
		endcase
	end

	assign crc_upd  = crc8_byte(is_data0 ? CRC_INIT : crc, item.data_byte);
	assign mismatch = is_crc && (crc != item.data_byte);
	assign vgood_n  = vgood && !mismatch;
	assign fgood_n  = fgood && !mismatch;
	assign last     = (count == LAST_INDEX);
	assign emit     = item.valid && (phase == PH_LAST);

	assign result = '{
		value_bits:  hold_q,
		value_index: count,
		value_ok:    vgood_n,
		frame_end:   last,
		frame_ok:    last && fgood_n
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_D0;
			count_q <= '0;
			crc_q   <= CRC_INIT;
			vgood_q <= 1'b1;
			fgood_q <= 1'b1;
		end else if (fire) begin
			crc_q <= is_crc ? CRC_INIT : crc_upd;
			if (phase == PH_LAST) begin
				phase_q <= PH_D0;
				count_q <= last ? '0 : count + 1'b1;
				vgood_q <= 1'b1;
				fgood_q <= last ? 1'b1 : fgood_n;
			end else begin
				phase_q <= phase + 1'b1;
				count_q <= count;
				vgood_q <= vgood_n;
				fgood_q <= fgood_n;
			end
		end
	end

	// Every value shifts in four fresh data bytes, so the hold needs no clear.
	always_ff @(posedge clk) begin
		if (fire && !is_crc) begin
			hold_q <= {hold_q[VALUE_W-BYTE_W-1:0], item.data_byte};
		end
	end

endmodule

### hw/rtl/c8wpd_out_stage.sv
// Result register of the word-pair deframer.
// Depends on c8wpd_pkg.
module c8wpd_out_stage
	import c8wpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  result_t            result,
	output logic               take,
	output logic               value_valid,
	input  logic               value_ready,
	output logic [VALUE_W-1:0] value_bits,
	output logic [INDEX_W-1:0] value_index,
	output logic               value_ok,
	output logic               frame_end,
	output logic               frame_ok
);

	logic    valid_s2;
	result_t result_s2;

	// Accept a new result when empty or when the held one leaves now.
	assign take = !valid_s2 || value_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (take && load) begin
			result_s2 <= result;
		end
	end

	assign value_valid = valid_s2;
	assign value_bits  = result_s2.value_bits;
	assign value_index = result_s2.value_index;
	assign value_ok    = result_s2.value_ok;
	assign frame_end   = result_s2.frame_end;
	assign frame_ok    = result_s2.frame_ok;

endmodule

### hw/rtl/c8wpd_checker.sv
// Port-level checker for the word-pair deframer, bound to the top level.
// Depends on c8wpd_pkg and crc8_word_pair_deframer.
module c8wpd_checker
	import c8wpd_pkg::*;
#(
	parameter int unsigned VALUE_COUNT = 10
) (
	input logic               clk,
	input logic               arst_n,
	input logic               value_valid,
	input logic               value_ready,
	input logic [INDEX_W-1:0] value_index,
	input logic               value_ok,
	input logic               frame_end,
	input logic               frame_ok
);

	localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(VALUE_COUNT - 1);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		value_valid && !value_ready |=> value_valid)
		else $error("value_valid dropped while stalled");

	a_ok_needs_end: assert property (@(posedge clk) disable iff (!arst_n)
		value_valid && frame_ok |-> frame_end)
		else $error("frame_ok without frame_end");

	a_end_index: assert property (@(posedge clk) disable iff (!arst_n)
		value_valid |-> (frame_end == (value_index == LAST_INDEX)))
		else $error("frame_end does not match last index");

	a_bad_value_bad_frame: assert property (@(posedge clk) disable iff (!arst_n)
		value_valid && frame_end && !value_ok |-> !frame_ok)
		else $error("frame_ok set with a bad last value");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		value_valid |-> value_index <= LAST_INDEX)
		else $error("value_index beyond frame length");

endmodule

bind crc8_word_pair_deframer c8wpd_checker #(
	.VALUE_COUNT (VALUE_COUNT)
) u_c8wpd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.value_valid (value_valid),
	.value_ready (value_ready),
	.value_index (value_index),
	.value_ok    (value_ok),
	.frame_end   (frame_end),
	.frame_ok    (frame_ok)
);

### bench/crc8_word_pair_deframer_test.sv
// Self-checking bench for crc8_word_pair_deframer: byte stream in, assembled values out.
// Depends on c8wpd_pkg and the deframer RTL. A built-in tracker predicts every value
// transaction, and the bench checks each one against the oldest prediction.
module crc8_word_pair_deframer_test
	import c8wpd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned VALUES_PER_FRAME = 10;
	localparam int unsigned BYTES_PER_VALUE  = 6;
	localparam int unsigned FRAME_BYTES      = VALUES_PER_FRAME * BYTES_PER_VALUE;
	localparam int unsigned IDLE_PCT         = 19;
	localparam int unsigned HOLD_CYCLES      = 400;   // long receiver hold-off
	localparam int unsigned STALL_LIMIT      = 4000;  // cycles with no transaction at all
	localparam int unsigned DRAIN_CYCLES     = 8;     // two-stage pipe plus margin
	localparam int unsigned REPORT_MAX       = 10;

	logic               clk;
	logic               arst_n      = 1'b0;
	logic               byte_valid  = 1'b0;
	logic               byte_ready;
	logic [BYTE_W-1:0]  data_byte   = '0;
	logic               frame_start = 1'b0;
	logic               value_valid;
	logic               value_ready = 1'b0;
	logic [VALUE_W-1:0] value_bits;
	logic [INDEX_W-1:0] value_index;
	logic               value_ok;
	logic               frame_end;
	logic               frame_ok;

	// Shared between the test tasks and the receiver process.
	bit no_gaps       = 1'b0;
	bit hold_off_req  = 1'b0;

	// Tracker state: our own view of where the block is in the frame.
	int unsigned        byte_pos;
	logic [7:0]         triplet_crc;
	logic [31:0]        word_acc;
	bit                 word_crc_good;
	bit                 frame_crc_good;
	logic [INDEX_W-1:0] word_idx;

	result_t            pending_values[$];

	int unsigned bytes_sent;
	int unsigned values_checked;
	int unsigned frame_ends_seen;
	int unsigned bad_values_seen;
	int unsigned good_frames_seen;
	int unsigned mismatches;
	int unsigned unexpected_values;

	crc8_word_pair_deframer #(
		.VALUE_COUNT(VALUES_PER_FRAME)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.value_valid (value_valid),
		.value_ready (value_ready),
		.value_bits  (value_bits),
		.value_index (value_index),
		.value_ok    (value_ok),
		.frame_end   (frame_end),
		.frame_ok    (frame_ok)
	);

	// 20 ns period: low half, then high half.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------
	// CRC and frame tracker
	// ------------------------------------------------------------------

	// Bit-serial form of the CRC-8 (poly 0x31): shift in one data bit at a time, MSB first.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] r;
		logic       fb;
		r = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[7] ^ b[i];
			r  = {r[6:0], 1'b0};
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	task automatic restart_tracker();
		byte_pos       = 0;
		triplet_crc    = CRC_INIT;
		word_acc       = '0;
		word_crc_good  = 1'b1;
		frame_crc_good = 1'b1;
		word_idx       = '0;
	endtask

	// Advance the tracker by one accepted byte; queue the value that it completes, if any.
	task automatic track_byte(input logic [7:0] b, input logic s);
		logic [PHASE_W-1:0] ph;
		result_t            r;
		bit                 last;
		if (s || byte_pos >= FRAME_BYTES) begin
			restart_tracker();
		end
		ph = PHASE_W'(byte_pos % BYTES_PER_VALUE);
		if (ph == PH_D0 || ph == PH_D3) begin
			// First data byte of a triplet: reseed the CRC.
			triplet_crc = crc8_update(CRC_INIT, b);
			word_acc    = {word_acc[23:0], b};
		end else if (ph == PH_D1 || ph == PH_D4) begin
			triplet_crc = crc8_update(triplet_crc, b);
			word_acc    = {word_acc[23:0], b};
		end else begin
			// CRC byte: compare, never store.
			if (triplet_crc != b) begin
				word_crc_good  = 1'b0;
				frame_crc_good = 1'b0;
			end
			triplet_crc = CRC_INIT;
		end
		if (ph == PH_LAST) begin
			last          = (word_idx == INDEX_W'(VALUES_PER_FRAME - 1));
			r.value_bits  = word_acc;
			r.value_index = word_idx;
			r.value_ok    = word_crc_good;
			r.frame_end   = last;
			r.frame_ok    = last && frame_crc_good;
			pending_values.push_back(r);
			word_acc      = '0;
			word_crc_good = 1'b1;
			word_idx      = word_idx + 1'b1;
		end
		byte_pos++;
		if (byte_pos >= FRAME_BYTES) begin
			restart_tracker();
		end
	endtask

	// ------------------------------------------------------------------
	// Byte channel driver
	// ------------------------------------------------------------------

	// Offer one byte; hold valid and payload until the block takes it. Call at a rising edge.
	task automatic send_byte(input logic [7:0] b, input logic s);
		if (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
			// Drop valid for a short, random gap so idles land on every phase.
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		byte_valid  <= 1'b1;
		data_byte   <= b;
		frame_start <= s;
		@(posedge clk);
		while (!byte_ready) begin
			@(posedge clk);
		end
		track_byte(b, s);
		bytes_sent++;
	endtask

	function automatic logic [7:0] pick_byte();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 8) begin
			return 8'h00;
		end else if (k < 16) begin
			return 8'hFF;
		end
		return 8'($urandom);
	endfunction

	function automatic logic [31:0] pick_word();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 5) begin
			return 32'h0000_0000;
		end else if (k < 10) begin
			return 32'hFFFF_FFFF;
		end
		return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
	endfunction

	// Send one six-byte value: two data/data/CRC triplets. bad[0] spoils the first
	// CRC byte, bad[1] the second. Take only the first n_bytes of the six.
	task automatic send_value(input logic [31:0] w, input logic s, input logic [1:0] bad,
			input int unsigned n_bytes);
		logic [7:0] seq[6];
		logic [7:0] spoil;
		seq[0] = w[31:24];
		seq[1] = w[23:16];
		seq[2] = crc8_update(crc8_update(CRC_INIT, seq[0]), seq[1]);
		seq[3] = w[15:8];
		seq[4] = w[7:0];
		seq[5] = crc8_update(crc8_update(CRC_INIT, seq[3]), seq[4]);
		spoil = 8'($urandom_range(1, 255));
		if (bad[0]) begin
			seq[2] = seq[2] ^ spoil;
		end
		if (bad[1]) begin
			seq[5] = seq[5] ^ spoil;
		end
		for (int i = 0; i < n_bytes; i++) begin
			send_byte(seq[i], (i == 0) ? s : 1'b0);
		end
	endtask

	// Send n_values well-formed values with random content; each CRC goes bad with bad_pct odds.
	task automatic send_frame(input logic s, input int unsigned bad_pct,
			input int unsigned n_values);
		logic [1:0] bad;
		for (int v = 0; v < n_values; v++) begin
			bad[0] = $urandom_range(0, 99) < bad_pct;
			bad[1] = $urandom_range(0, 99) < bad_pct;
			send_value(pick_word(), (v == 0) ? s : 1'b0, bad, BYTES_PER_VALUE);
		end
	endtask

	// ------------------------------------------------------------------
	// Value channel: receiver and checker
	// ------------------------------------------------------------------

	// Toggle ready at random; on request, hold ready low through a hold-off counted here, then clear the request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				value_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
			value_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Sample at the rising edge: these are the values the block saw at this edge.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && value_valid && value_ready) begin
			got.value_bits  = value_bits;
			got.value_index = value_index;
			got.value_ok    = value_ok;
			got.frame_end   = frame_end;
			got.frame_ok    = frame_ok;
			if (pending_values.size() == 0) begin
				unexpected_values++;
				if (mismatches + unexpected_values <= REPORT_MAX) begin
					$display("%0t: value with none predicted: bits=%h idx=%0d ok=%b end=%b fok=%b",
						$realtime, got.value_bits, got.value_index, got.value_ok,
						got.frame_end, got.frame_ok);
				end
			end else begin
				want = pending_values.pop_front();
				values_checked++;
				if (!want.value_ok) begin
					bad_values_seen++;
				end
				if (want.frame_end) begin
					frame_ends_seen++;
				end
				if (want.frame_ok) begin
					good_frames_seen++;
				end
				if (got.value_bits != want.value_bits || got.value_index != want.value_index ||
						got.value_ok != want.value_ok || got.frame_end != want.frame_end ||
						got.frame_ok != want.frame_ok) begin
					mismatches++;
					if (mismatches + unexpected_values <= REPORT_MAX) begin
						$display("%0t: mismatch: want bits=%h idx=%0d ok=%b end=%b fok=%b",
							$realtime, want.value_bits, want.value_index, want.value_ok,
							want.frame_end, want.frame_ok);
						$display("%0t:             got bits=%h idx=%0d ok=%b end=%b fok=%b",
							$realtime, got.value_bits, got.value_index, got.value_ok,
							got.frame_end, got.frame_ok);
					end
				end
			end
		end
	end

	// Watchdog: end the run once the quiet count, cleared by any transaction on either channel, reaches STALL_LIMIT.
	always @(posedge clk) begin
		int unsigned quiet;
		if ((byte_valid && byte_ready) || (value_valid && value_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
		end
		if (quiet >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d values outstanding",
				$realtime, STALL_LIMIT, pending_values.size());
			$display("crc8_word_pair_deframer_test: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Field extremes, bad CRCs, and a frame start that cuts a value short.
	task automatic test_directed();
		// All-zero value with good CRCs opens the frame.
		send_value(32'h0000_0000, 1'b1, 2'b00, BYTES_PER_VALUE);
		// All-ones value with the first CRC spoiled: value_ok drops, frame goes bad.
		send_value(32'hFFFF_FFFF, 1'b0, 2'b01, BYTES_PER_VALUE);
		// Five bytes of a value, then a frame start: drop the partial value silently.
		send_value(32'hBEEF_A55A, 1'b0, 2'b00, 5);
		// Fresh frame; index restarts at zero.
		send_value(32'h8000_0001, 1'b1, 2'b10, BYTES_PER_VALUE);
	endtask

	// Bulk of the run: whole frames with random content, about half of them sent with no CRC spoiled.
	task automatic test_random_frames();
		for (int f = 0; f < 18; f++) begin
			send_frame(1'b1, ($urandom_range(0, 1) == 0) ? 0 : 6, VALUES_PER_FRAME);
		end
	endtask

	// Frames back to back without frame_start: position must wrap on its own.
	task automatic test_frame_wrap();
		send_frame(1'b1, 0, VALUES_PER_FRAME);
		send_frame(1'b0, 3, VALUES_PER_FRAME);
		send_frame(1'b0, 0, VALUES_PER_FRAME);
	endtask

	// Broken frames and raw noise with scattered frame starts.
	task automatic test_noise();
		for (int f = 0; f < 8; f++) begin
			send_frame(1'b1, 10, $urandom_range(1, VALUES_PER_FRAME - 1));
			send_value(pick_word(), 1'b0, 2'($urandom), $urandom_range(1, 5));
		end
		for (int i = 0; i < 150; i++) begin
			send_byte(pick_byte(), $urandom_range(0, 99) < 3);
		end
	endtask

	// Hold the value channel off long enough that the block stalls its byte input.
	task automatic test_backpressure();
		hold_off_req = 1'b1;
		send_frame(1'b1, 5, VALUES_PER_FRAME);
		send_frame(1'b0, 0, VALUES_PER_FRAME);
	endtask

	// A stretch at full rate on both sides.
	task automatic test_full_rate();
		no_gaps = 1'b1;
		send_frame(1'b1, 0, VALUES_PER_FRAME);
		send_frame(1'b1, 5, VALUES_PER_FRAME);
		no_gaps = 1'b0;
	endtask

	initial begin
		restart_tracker();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_frames();
		test_frame_wrap();
		test_noise();
		test_backpressure();
		test_full_rate();

		// Stop offering bytes, drain the pipe, then let it sit quiet for a margin.
		byte_valid <= 1'b0;
		while (pending_values.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes; checked %0d values (%0d with a bad CRC).",
			bytes_sent, values_checked, bad_values_seen);
		$display("Saw %0d frame ends, %0d of them with every CRC good.",
			frame_ends_seen, good_frames_seen);
		if (mismatches == 0 && unexpected_values == 0 && pending_values.size() == 0) begin
			$display("crc8_word_pair_deframer_test: clean");
		end else begin
			$display("crc8_word_pair_deframer_test: errors");
		end
		$finish;
	end

endmodule
